### src/crcs_pkg.sv
// crcs_pkg: constants, control types and the microcode table of the curve sampler.
// No dependencies; used by crcs_sequencer, crcs_datapath and the top level.
package crcs_pkg;

	localparam int COORD_BITS     = 16;
	localparam int MAX_STEPS_LOG2 = 6;
	localparam int OUT_BITS       = COORD_BITS + 1;
	localparam int CFG_BITS       = 3;
	localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(4);
	localparam int NUM_COORDS     = 3;
	localparam int CF_W           = COORD_BITS + 5;
	localparam int ACC_W          = COORD_BITS + 3 * MAX_STEPS_LOG2 + 6;
	localparam int SH_W           = $clog2(3 * MAX_STEPS_LOG2 + 2);
	localparam int IDX_W          = MAX_STEPS_LOG2;
	localparam int KW             = $clog2(MAX_STEPS_LOG2 + 1);
	localparam int STEP_W         = 4;

	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_FIRST = 3'd1,
		OP_MID   = 3'd2,
		OP_LAST  = 3'd3,
		OP_EMIT  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		BR_NEXT  = 2'd0,
		BR_START = 2'd1,
		BR_LOOP  = 2'd2,
		BR_JUMP  = 2'd3
	} br_t;

	typedef logic [1:0] coord_t;
	typedef logic [STEP_W-1:0] step_t;

	localparam coord_t COORD_X = 2'd0;
	localparam coord_t COORD_Y = 2'd1;
	localparam coord_t COORD_Z = 2'd2;

	localparam step_t STEP_IDLE = step_t'(0);
	localparam step_t STEP_PROG = step_t'(1);
	localparam step_t STEP_EMIT = step_t'(10);

	typedef struct packed {
		op_t    op;
		coord_t coord;
		br_t    br;
		step_t  target;
	} uword_t;

	typedef struct packed {
		op_t    op;
		coord_t coord;
	} ctrl_t;

	typedef struct packed {
		logic last;
	} dp_status_t;

	// Horner per coordinate: ((a3*i + a2*n)*i + a1*n^2)*i + a0*n^3
	function automatic uword_t ucode_rom(step_t s);
		uword_t w;
		case (s)
			step_t'(0):  w = '{op: OP_NOP,   coord: COORD_X, br: BR_START, target: STEP_PROG};
			step_t'(1):  w = '{op: OP_FIRST, coord: COORD_X, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(2):  w = '{op: OP_MID,   coord: COORD_X, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(3):  w = '{op: OP_LAST,  coord: COORD_X, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(4):  w = '{op: OP_FIRST, coord: COORD_Y, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(5):  w = '{op: OP_MID,   coord: COORD_Y, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(6):  w = '{op: OP_LAST,  coord: COORD_Y, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(7):  w = '{op: OP_FIRST, coord: COORD_Z, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(8):  w = '{op: OP_MID,   coord: COORD_Z, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(9):  w = '{op: OP_LAST,  coord: COORD_Z, br: BR_NEXT,  target: STEP_IDLE};
			step_t'(10): w = '{op: OP_EMIT,  coord: COORD_X, br: BR_LOOP,  target: STEP_IDLE};
			default:     w = '{op: OP_NOP,   coord: COORD_X, br: BR_JUMP,  target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

### src/crcs_sequencer.sv
// crcs_sequencer: step counter and microcode table lookup with conditional jumps.
// Depends on crcs_pkg.
module crcs_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                out_free,
	input  crcs_pkg::dp_status_t status,
	output crcs_pkg::ctrl_t     ctrl,
	output logic                idle
);

	crcs_pkg::step_t  step_q;
	crcs_pkg::step_t  step_d;
	crcs_pkg::uword_t uw;
	logic             stall;

	assign uw    = crcs_pkg::ucode_rom(step_q);
	assign stall = (uw.op == crcs_pkg::OP_EMIT) && !out_free;
	assign idle  = (step_q == crcs_pkg::STEP_IDLE);

	always_comb begin
		ctrl.op    = stall ? crcs_pkg::OP_NOP : uw.op;
		ctrl.coord = uw.coord;
	end

	always_comb begin
		case (uw.br)
			crcs_pkg::BR_NEXT:  step_d = step_q + 1'b1;
			crcs_pkg::BR_START: step_d = start ? uw.target : step_q;
			crcs_pkg::BR_LOOP: begin
				if (stall)
					step_d = step_q;
				else if (status.last)
					step_d = uw.target;
				else
					step_d = crcs_pkg::STEP_PROG;
			end
			crcs_pkg::BR_JUMP:  step_d = uw.target;
			default:            step_d = crcs_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= crcs_pkg::STEP_IDLE;
		else
			step_q <= step_d;
	end

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == crcs_pkg::OP_EMIT |-> out_free)
		else $error("emit issued while output slot busy");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == crcs_pkg::OP_EMIT && status.last) |=> step_q == crcs_pkg::STEP_IDLE)
		else $error("sequencer did not return to idle after last sample");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == crcs_pkg::STEP_EMIT && !out_free) |=> $stable(step_q))
		else $error("step moved while output stalled");

	a_step_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= crcs_pkg::STEP_EMIT)
		else $error("step counter left the program");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && start) |=> step_q == crcs_pkg::STEP_PROG)
		else $error("start did not enter the program");

endmodule

### src/crcs_datapath.sv
// crcs_datapath: point window, basis coefficients, shared multiply-add and result registers.
// Depends on crcs_pkg; driven by crcs_sequencer control words.
module crcs_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  logic signed [crcs_pkg::COORD_BITS-1:0]  point_x,
	input  logic signed [crcs_pkg::COORD_BITS-1:0]  point_y,
	input  logic signed [crcs_pkg::COORD_BITS-1:0]  point_z,
	input  logic        [crcs_pkg::CFG_BITS-1:0]    seg_log2,
	input  crcs_pkg::ctrl_t                         ctrl,
	output crcs_pkg::dp_status_t                    status,
	output logic                                    primed,
	output logic signed [crcs_pkg::OUT_BITS-1:0]    res_x,
	output logic signed [crcs_pkg::OUT_BITS-1:0]    res_y,
	output logic signed [crcs_pkg::OUT_BITS-1:0]    res_z
);

	localparam int CB = crcs_pkg::COORD_BITS;
	localparam int CW = crcs_pkg::CF_W;
	localparam int AW = crcs_pkg::ACC_W;
	localparam int IW = crcs_pkg::IDX_W;
	localparam int NC = crcs_pkg::NUM_COORDS;

	logic signed [CB-1:0] win_q [3][NC];
	logic signed [CB-1:0] pt    [NC];
	logic [1:0]           seen_q;

	logic signed [CW-1:0] a0_q [NC];
	logic signed [CW-1:0] a1_q [NC];
	logic signed [CW-1:0] a2_q [NC];
	logic signed [CW-1:0] a3_q [NC];
	logic signed [CW-1:0] a0_d [NC];
	logic signed [CW-1:0] a1_d [NC];
	logic signed [CW-1:0] a2_d [NC];
	logic signed [CW-1:0] a3_d [NC];

	logic [crcs_pkg::KW-1:0]   k_q;
	logic [crcs_pkg::KW-1:0]   k_eff;
	logic [IW-1:0]             i_q;
	logic [IW:0]               n_val;
	logic [crcs_pkg::SH_W-1:0] sh1, sh2, sh3, shf;

	logic signed [AW-1:0]    acc_q;
	logic signed [AW-1:0]    mul_a;
	logic signed [AW+IW:0]   prod;
	logic signed [AW-1:0]    addend;
	logic signed [AW-1:0]    sum;
	logic signed [AW-1:0]    shifted;
	logic signed [crcs_pkg::OUT_BITS-1:0] res_q [NC];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	assign primed = (seen_q == 2'd3);
	assign k_eff  = (seg_log2 > crcs_pkg::CFG_BITS'(crcs_pkg::MAX_STEPS_LOG2)) ?
		crcs_pkg::KW'(crcs_pkg::MAX_STEPS_LOG2) : crcs_pkg::KW'(seg_log2);

	assign n_val       = (IW + 1)'(1) << k_q;
	assign status.last = (i_q == IW'(n_val - 1'b1));

	assign sh1 = crcs_pkg::SH_W'(k_q);
	assign sh2 = sh1 << 1;
	assign sh3 = sh1 + sh2;
	assign shf = sh3 + 1'b1;

	always_comb begin
		logic signed [CW-1:0] e0, e1, e2, e3;
		for (int c = 0; c < NC; c++) begin
			e0 = CW'(win_q[0][c]);
			e1 = CW'(win_q[1][c]);
			e2 = CW'(win_q[2][c]);
			e3 = CW'(pt[c]);
			a0_d[c] = e1 <<< 1;
			a1_d[c] = e2 - e0;
			a2_d[c] = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
			a3_d[c] = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
			for (int w = 0; w < 3; w++)
				for (int c = 0; c < NC; c++)
					win_q[w][c] <= '0;
		end else if (accept) begin
			if (!primed)
				seen_q <= seen_q + 1'b1;
			for (int c = 0; c < NC; c++) begin
				win_q[0][c] <= win_q[1][c];
				win_q[1][c] <= win_q[2][c];
				win_q[2][c] <= pt[c];
			end
		end
	end

	assign mul_a = (ctrl.op == crcs_pkg::OP_FIRST) ? AW'(a3_q[ctrl.coord]) : acc_q;
	assign prod  = mul_a * $signed({1'b0, i_q});

	always_comb begin
		case (ctrl.op)
			crcs_pkg::OP_FIRST: addend = AW'(a2_q[ctrl.coord]) <<< sh1;
			crcs_pkg::OP_MID:   addend = AW'(a1_q[ctrl.coord]) <<< sh2;
			crcs_pkg::OP_LAST:  addend = AW'(a0_q[ctrl.coord]) <<< sh3;
			default:            addend = '0;
		endcase
	end

	assign sum     = AW'(prod) + addend;
	assign shifted = sum >>> shf;

	always_ff @(posedge clk) begin
		if (accept) begin
			k_q <= k_eff;
			i_q <= '0;
			for (int c = 0; c < NC; c++) begin
				a0_q[c] <= a0_d[c];
				a1_q[c] <= a1_d[c];
				a2_q[c] <= a2_d[c];
				a3_q[c] <= a3_d[c];
			end
		end else begin
			case (ctrl.op)
				crcs_pkg::OP_FIRST,
				crcs_pkg::OP_MID:  acc_q <= sum;
				crcs_pkg::OP_LAST: res_q[ctrl.coord] <= shifted[crcs_pkg::OUT_BITS-1:0];
				crcs_pkg::OP_EMIT: i_q <= i_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign res_x = res_q[0];
	assign res_y = res_q[1];
	assign res_z = res_q[2];

endmodule

### src/catmull_rom_curve_sampler_top.sv
// catmull_rom_curve_sampler_top: uniform Catmull-Rom curve sampler, top level.
// Depends on crcs_pkg, crcs_sequencer and crcs_datapath.
//
// Input channel (in_valid/in_ready) carries one 3-D control point per transaction.
// The first three points only fill the window. Every later point closes the segment
// between the two middle points and produces 2^k samples, k = segment_steps_log2
// (clamped to 6), written through cfg_we/cfg_wdata while the block is idle.
// Output channel (out_valid/out_ready) carries one sample per transaction;
// last_of_segment marks the final sample of a segment.
// Timing: one shared multiply-add runs three Horner steps per coordinate, so the
// coordinates of a sample are worked out one after another before its emit step;
// a point with output occupies the block until its last sample is emitted, while
// warm-up points are taken without leaving the idle step.
// in_ready is high only while the sequencer is idle. A finished sample waits in the
// output register while the next one is computed; if the receiver still stalls,
// the sequencer holds at its emit step. Reset clears the window, the point count,
// the output valid and sets segment_steps_log2 to 4.
module catmull_rom_curve_sampler_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic        [crcs_pkg::CFG_BITS-1:0]    cfg_wdata,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [crcs_pkg::COORD_BITS-1:0]  point_x,
	input  logic signed [crcs_pkg::COORD_BITS-1:0]  point_y,
	input  logic signed [crcs_pkg::COORD_BITS-1:0]  point_z,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [crcs_pkg::OUT_BITS-1:0]    curve_x,
	output logic signed [crcs_pkg::OUT_BITS-1:0]    curve_y,
	output logic signed [crcs_pkg::OUT_BITS-1:0]    curve_z,
	output logic                                    last_of_segment
);

	logic [crcs_pkg::CFG_BITS-1:0] seg_log2_q;
	logic                          accept;
	logic                          primed;
	logic                          idle;
	logic                          out_free;
	logic                          out_valid_q;
	crcs_pkg::ctrl_t               ctrl;
	crcs_pkg::dp_status_t          status;
	logic signed [crcs_pkg::OUT_BITS-1:0] res_x, res_y, res_z;
	logic signed [crcs_pkg::OUT_BITS-1:0] curve_x_q, curve_y_q, curve_z_q;
	logic                          last_q;

	assign in_ready = idle;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seg_log2_q <= crcs_pkg::CFG_RESET;
		else if (cfg_we)
			seg_log2_q <= cfg_wdata;
	end

	crcs_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && primed),
		.out_free (out_free),
		.status   (status),
		.ctrl     (ctrl),
		.idle     (idle)
	);

	crcs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.seg_log2 (seg_log2_q),
		.ctrl     (ctrl),
		.status   (status),
		.primed   (primed),
		.res_x    (res_x),
		.res_y    (res_y),
		.res_z    (res_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.op == crcs_pkg::OP_EMIT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == crcs_pkg::OP_EMIT) begin
			curve_x_q <= res_x;
			curve_y_q <= res_y;
			curve_z_q <= res_z;
			last_q    <= status.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign curve_x         = curve_x_q;
	assign curve_y         = curve_y_q;
	assign curve_z         = curve_z_q;
	assign last_of_segment = last_q;

endmodule

### tb/sv/tb.sv
// tb: self-checking testbench for catmull_rom_curve_sampler_top.
// Depends on crcs_pkg and the sampler RTL; predicts every curve sample in integer
// arithmetic and checks samples in order under random stalls on both channels.
module tb;

	typedef struct {
		logic [crcs_pkg::OUT_BITS-1:0] x;
		logic [crcs_pkg::OUT_BITS-1:0] y;
		logic [crcs_pkg::OUT_BITS-1:0] z;
		logic                          last;
	} curve_sample_t;

	localparam int DRAIN_CYCLES = 16;

	logic                                    clk;
	logic                                    arst_n;
	logic                                    cfg_we;
	logic [crcs_pkg::CFG_BITS-1:0]           cfg_wdata;
	logic                                    in_valid;
	logic                                    in_ready;
	logic signed [crcs_pkg::COORD_BITS-1:0]  point_x;
	logic signed [crcs_pkg::COORD_BITS-1:0]  point_y;
	logic signed [crcs_pkg::COORD_BITS-1:0]  point_z;
	logic                                    out_valid;
	logic                                    out_ready;
	logic signed [crcs_pkg::OUT_BITS-1:0]    curve_x;
	logic signed [crcs_pkg::OUT_BITS-1:0]    curve_y;
	logic signed [crcs_pkg::OUT_BITS-1:0]    curve_z;
	logic                                    last_of_segment;

	// predictor state
	logic [crcs_pkg::CFG_BITS-1:0] steps_log2;
	longint                        window[3][3];
	int                            points_seen;
	curve_sample_t                 pending_samples[$];

	bit                  quiet;
	int                  fail_count;
	int                  points_sent;
	int                  samples_checked;
	logic [7:0]          settings_used;

	catmull_rom_curve_sampler_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.curve_x         (curve_x),
		.curve_y         (curve_y),
		.curve_z         (curve_z),
		.last_of_segment (last_of_segment)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic predict_segment_samples(
			input logic signed [crcs_pkg::COORD_BITS-1:0] px,
			input logic signed [crcs_pkg::COORD_BITS-1:0] py,
			input logic signed [crcs_pkg::COORD_BITS-1:0] pz);
		longint p3[3];
		longint a0[3], a1[3], a2[3], a3[3];
		longint n, i, s;
		logic [63:0] v[3];
		int k, c;
		curve_sample_t smp;
		p3[0] = px;
		p3[1] = py;
		p3[2] = pz;
		if (points_seen >= 3) begin
			k = (steps_log2 > crcs_pkg::MAX_STEPS_LOG2) ? crcs_pkg::MAX_STEPS_LOG2 :
				int'(steps_log2);
			n = longint'(1) << k;
			for (c = 0; c < 3; c++) begin
				a0[c] = 2 * window[1][c];
				a1[c] = window[2][c] - window[0][c];
				a2[c] = 2 * window[0][c] - 5 * window[1][c] + 4 * window[2][c] - p3[c];
				a3[c] = -window[0][c] + 3 * window[1][c] - 3 * window[2][c] + p3[c];
			end
			for (i = 0; i < n; i++) begin
				for (c = 0; c < 3; c++) begin
					s = a0[c] * n * n * n + a1[c] * i * n * n + a2[c] * i * i * n
						+ a3[c] * i * i * i;
					v[c] = s >>> (3 * k + 1);
				end
				smp.x = v[0][crcs_pkg::OUT_BITS-1:0];
				smp.y = v[1][crcs_pkg::OUT_BITS-1:0];
				smp.z = v[2][crcs_pkg::OUT_BITS-1:0];
				smp.last = (i == n - 1);
				pending_samples.insert(pending_samples.size(), smp);
			end
		end else begin
			points_seen++;
		end
		for (c = 0; c < 3; c++) begin
			window[0][c] = window[1][c];
			window[1][c] = window[2][c];
			window[2][c] = p3[c];
		end
	endtask

	task automatic send_point(input logic signed [crcs_pkg::COORD_BITS-1:0] px,
			input logic signed [crcs_pkg::COORD_BITS-1:0] py,
			input logic signed [crcs_pkg::COORD_BITS-1:0] pz);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			point_x <= crcs_pkg::COORD_BITS'($urandom);
			point_y <= crcs_pkg::COORD_BITS'($urandom);
			point_z <= crcs_pkg::COORD_BITS'($urandom);
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		do @(posedge clk); while (!in_ready);
		predict_segment_samples(px, py, pz);
		points_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_steps(input logic [crcs_pkg::CFG_BITS-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= crcs_pkg::CFG_BITS'($urandom);
		steps_log2 = val;
		settings_used[val] = 1'b1;
	endtask

	function automatic logic [crcs_pkg::COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
			default: return crcs_pkg::COORD_BITS'($urandom);
		endcase
	endfunction

	task automatic compare_field(input string name,
			input logic [crcs_pkg::OUT_BITS-1:0] exp_v,
			input logic [crcs_pkg::OUT_BITS-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name,
				$signed(exp_v), $signed(act_v));
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		curve_sample_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t unexpected sample: expected none actual %0d %0d %0d", $time,
					curve_x, curve_y, curve_z);
				fail_count++;
			end else begin
				e = pending_samples.pop_front();
				compare_field("curve_x", e.x, curve_x);
				compare_field("curve_y", e.y, curve_y);
				compare_field("curve_z", e.z, curve_z);
				compare_field("last_of_segment", crcs_pkg::OUT_BITS'(e.last),
					crcs_pkg::OUT_BITS'(last_of_segment));
				samples_checked++;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// reset value of the step register, warm-up, then full-scale points
	task automatic test_warmup_default();
		send_point(16'sh0100, -16'sh0200, 16'sh0300);
		send_point(16'sh7fff, 16'sh8000, 16'sh0000);
		send_point(16'sh8000, 16'sh7fff, -16'sh0001);
		send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_point(16'sh8000, 16'sh8000, 16'sh8000);
		settings_used[crcs_pkg::CFG_RESET] = 1'b1;
	endtask

	task automatic test_zero_steps();
		write_steps(3'd0);
		send_point(16'sh1234, -16'sh4321, 16'sh7fff);
		send_point(-16'sh0001, 16'sh0001, 16'sh8000);
		send_point(16'sh0000, 16'sh0000, 16'sh0000);
	endtask

	task automatic test_step_clamp();
		write_steps(3'd7);
		send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
		send_point(-16'sh0005, 16'sh0003, -16'sh0007);
	endtask

	// alternating extremes drive the curve past the control point range
	task automatic test_max_steps_overshoot();
		write_steps(3'd6);
		send_point(16'sh8000, 16'sh7fff, 16'sh8000);
		send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
		send_point(16'sh8000, 16'sh7fff, 16'sh8000);
		send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
		write_steps(3'd1);
		send_point(16'sh8000, 16'sh7fff, 16'sh8000);
		send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
	endtask

	task automatic test_random_segments();
		int r, burst;
		logic [crcs_pkg::CFG_BITS-1:0] k;
		while (points_sent < 300) begin
			r = $urandom_range(0, 9);
			if (r < 6) k = crcs_pkg::CFG_BITS'($urandom_range(0, 3));
			else if (r < 8) k = 3'd4;
			else if (r < 9) k = 3'd5;
			else k = crcs_pkg::CFG_BITS'($urandom_range(6, 7));
			write_steps(k);
			burst = $urandom_range(8, 30);
			repeat (burst) send_point(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	task automatic test_no_idle();
		write_steps(crcs_pkg::CFG_BITS'($urandom_range(2, 4)));
		quiet = 1'b1;
		repeat (20) send_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		quiet = 1'b0;
		fail_count = 0;
		points_sent = 0;
		samples_checked = 0;
		settings_used = '0;
		steps_log2 = crcs_pkg::CFG_RESET;
		points_seen = 0;
		foreach (window[a, b]) window[a][b] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_warmup_default();
		test_zero_steps();
		test_step_clamp();
		test_max_steps_overshoot();
		test_random_segments();
		test_no_idle();

		wait_drained();
		$display("Sent %0d control points and checked %0d curve samples,", points_sent,
			samples_checked);
		$display("step settings used (bit per value 7..0): %b", settings_used);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
